// ===== src/xtce_pkg.sv =====
// Package for the tag-content extractor: window geometry, tag constants,
// result kinds and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package xtce_pkg;

  localparam int WIN_LEN   = 14;
  localparam int WIN_BITS  = 8 * WIN_LEN;
  localparam int FLUSH_LEN = WIN_LEN - 7;
  localparam int IDX_W     = $clog2(FLUSH_LEN);

  localparam logic [8*13-1:0] OPEN_DESC  = "<Description>";
  localparam logic [8*6-1:0]  OPEN_NAME  = "<Name>";
  localparam logic [8*14-1:0] CLOSE_DESC = "</Description>";
  localparam logic [8*7-1:0]  CLOSE_NAME = "</Name>";

  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ABANDON = 2'd2;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_REL  = 2'd1;
  localparam logic [1:0] SEL_SCAN = 2'd2;

  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       marks_clr;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] out_sel;
    logic       out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic eoi;
    logic cap;
    logic rel;
    logic close_hit;
    logic close_name;
    logic scan_mark;
    logic scan_end;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== src/xtce_datapath.sv =====
// Datapath of the tag-content extractor: byte window with content marks,
// tag matchers, flush index and the output register.
// Depends on xtce_pkg.
`default_nettype none

module xtce_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_text_byte,
  input  wire logic              in_end_of_input,
  input  wire xtce_pkg::ctl_cmd_t cmd,
  output xtce_pkg::ctl_sts_t     sts,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_content_byte,
  output logic [1:0]             out_kind,
  output logic                   out_last_of_step
);
  import xtce_pkg::*;

  logic [WIN_BITS-1:0] win_r, win_nxt, win_sh;
  logic [WIN_LEN-1:0]  marks_r, marks_nxt, marks_sh;
  logic                cap_r, cap_nxt;
  logic [7:0]          rel_byte_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [1:0]          out_kind_r;
  logic                out_last_r;
  logic [3:0]          pos;
  logic [7:0]          scan_byte;
  logic                open_hit, desc_hit, name_hit;

  assign win_sh   = {win_r[WIN_BITS-9:0], in_text_byte};
  assign marks_sh = {marks_r[WIN_LEN-2:0], cap_r};

  assign open_hit = (win_sh[8*13-1:0] == OPEN_DESC) || (win_sh[8*6-1:0] == OPEN_NAME);
  assign desc_hit = (win_sh[8*14-1:0] == CLOSE_DESC);
  assign name_hit = (win_sh[8*7-1:0] == CLOSE_NAME);

  assign pos       = 4'(WIN_LEN - 1) - 4'(idx_r);
  assign scan_byte = win_r[{pos, 3'b000} +: 8];

  always_comb begin
    sts.eoi        = in_end_of_input;
    sts.cap        = cap_r;
    sts.rel        = marks_r[WIN_LEN-1];
    sts.close_hit  = cap_r && !in_end_of_input && (desc_hit || name_hit);
    sts.close_name = !desc_hit && name_hit;
    sts.scan_mark  = marks_r[pos];
    sts.scan_end   = (idx_r == IDX_W'(FLUSH_LEN - 1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    win_nxt   = win_r;
    marks_nxt = marks_r;
    cap_nxt   = cap_r;
    if (cmd.load) begin
      if (in_end_of_input) begin
        win_nxt   = '0;
        marks_nxt = '0;
        cap_nxt   = 1'b0;
      end else begin
        win_nxt   = win_sh;
        marks_nxt = marks_sh;
        if (!cap_r && open_hit) begin
          cap_nxt = 1'b1;
        end else if (cap_r && (desc_hit || name_hit)) begin
          cap_nxt = 1'b0;
        end
      end
    end else if (cmd.marks_clr) begin
      marks_nxt = '0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    unique case (cmd.out_sel)
      SEL_REL:  out_byte_nxt = rel_byte_r;
      SEL_SCAN: out_byte_nxt = scan_byte;
      default:  out_byte_nxt = 8'd0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      marks_r     <= '0;
      cap_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      marks_r     <= marks_nxt;
      cap_r       <= cap_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rel_byte_r <= win_r[WIN_BITS-1 -: 8];
    end
    if (cmd.out_load) begin
      out_byte_r <= out_byte_nxt;
      out_kind_r <= cmd.out_kind;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_content_byte = out_byte_r;
  assign out_kind         = out_kind_r;
  assign out_last_of_step = out_last_r;

endmodule

`default_nettype wire

// ===== src/xtce_ctrl.sv =====
// Controller of the tag-content extractor: sequences release, flush,
// end marker and abandon results for each accepted byte.
// Depends on xtce_pkg.
`default_nettype none

module xtce_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire xtce_pkg::ctl_sts_t sts,
  output xtce_pkg::ctl_cmd_t      cmd
);
  import xtce_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REL  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_ABN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       close_r, close_nxt;
  logic       flush_r, flush_nxt;

  always_comb begin
    state_nxt = state_r;
    close_nxt = close_r;
    flush_nxt = flush_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          close_nxt   = sts.close_hit;
          flush_nxt   = sts.close_name;
          if (sts.eoi) begin
            state_nxt = sts.cap ? S_ABN : S_IDLE;
          end else if (sts.rel) begin
            state_nxt = S_REL;
          end else if (sts.close_hit) begin
            state_nxt = sts.close_name ? S_SCAN : S_END;
          end
        end
      end
      S_REL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_CONTENT;
          cmd.out_sel  = SEL_REL;
          cmd.out_last = !close_r;
          if (close_r) begin
            state_nxt = flush_r ? S_SCAN : S_END;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (!sts.scan_mark || sts.out_free) begin
          cmd.idx_inc  = 1'b1;
          cmd.out_load = sts.scan_mark;
          cmd.out_kind = KIND_CONTENT;
          cmd.out_sel  = SEL_SCAN;
          if (sts.scan_end) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = KIND_END;
          cmd.out_sel   = SEL_ZERO;
          cmd.out_last  = 1'b1;
          cmd.marks_clr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ABN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_ABANDON;
          cmd.out_sel  = SEL_ZERO;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      close_r <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      close_r <= close_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/xml_tag_content_extractor.sv =====
// Top level of the tag-content extractor: controller plus datapath.
// Depends on xtce_pkg, xtce_ctrl and xtce_datapath.
//
// Bytes of a text stream enter one per transfer; the characters between an
// opening <Description> or <Name> tag and the next closing tag leave as
// content results, each closed by an end marker, and an end-of-input item
// inside an element gives an abandon result. A byte that causes no result
// leaves the controller ready for the next byte. After a byte that causes
// results, the controller walks its result states: one for the byte leaving
// the window, a flush walk over seven window positions after a closing Name
// tag (one position per cycle unless a marked position waits for the output
// register), and one for the end or abandon marker. Input is refused while
// the controller walks these states. Results leave through a one-entry
// output register, and the walk stalls while it is full and a result waits.
`default_nettype none

module xml_tag_content_extractor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_content_byte,
  output logic [1:0]      out_kind,
  output logic            out_last_of_step
);
  import xtce_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  xtce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xtce_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_text_byte     (in_text_byte),
    .in_end_of_input  (in_end_of_input),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_content_byte (out_content_byte),
    .out_kind         (out_kind),
    .out_last_of_step (out_last_of_step)
  );

endmodule

`default_nettype wire

// ===== src/xtce_checker.sv =====
// Port-level checker for the tag-content extractor, bound to the top level.
// Depends on xtce_pkg.
`default_nettype none

module xtce_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_content_byte,
  input wire logic [1:0] out_kind,
  input wire logic       out_last_of_step
);
  import xtce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_content_byte)
      && $stable(out_kind) && $stable(out_last_of_step))
    else $error("result changed while stalled");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CONTENT |-> out_content_byte == 8'd0)
    else $error("marker result carries a nonzero byte");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CONTENT |-> out_last_of_step)
    else $error("marker result is not the last of its step");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_CONTENT || out_kind == KIND_END
      || out_kind == KIND_ABANDON)
    else $error("illegal result kind");

endmodule

bind xml_tag_content_extractor xtce_checker u_xtce_checker (.*);

`default_nettype wire
